FILE: rtl/core/rc4_pkg.sv
package rc4_pkg;

   localparam int PERM_SIZE     = 256;
   localparam int PERM_W        = 8;
   localparam int PERM_ADDR_W   = $clog2(PERM_SIZE);
   localparam int KEY_WORDS     = 4;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_BYTES     = KEY_WORDS * KEY_WORD_W / 8;
   localparam int KEY_POS_W     = $clog2(KEY_BYTES);
   localparam int KEY_LEN_W     = 6;
   localparam int MAX_KEY_BYTES = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = KEY_WORD_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_LENGTH = 3'd0,
      REG_KEY_WORD_0 = 3'd1,
      REG_KEY_WORD_1 = 3'd2,
      REG_KEY_WORD_2 = 3'd3,
      REG_KEY_WORD_3 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [KEY_LEN_W-1:0]                  length;
      logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] words;
   } key_type;

   typedef struct packed {
      logic                   we;
      logic [PERM_ADDR_W-1:0] waddr;
      logic [PERM_W-1:0]      wdata;
      logic                   re;
      logic [PERM_ADDR_W-1:0] raddr;
   } ram_req_type;

   // zero counts as one byte, anything past the key storage saturates
   function automatic logic [KEY_LEN_W-1:0] eff_key_length(input logic [KEY_LEN_W-1:0] len);
      logic [KEY_LEN_W-1:0] res;
      res = len;
      if (len == '0)
         res = KEY_LEN_W'(1);
      else if (len > KEY_LEN_W'(MAX_KEY_BYTES))
         res = KEY_LEN_W'(MAX_KEY_BYTES);
      return res;
   endfunction

endpackage

FILE: rtl/core/rc4_ifs.sv
interface rc4_req_if;
   import rc4_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] plain_byte;
   logic       end_of_message;

   modport source (output valid, output plain_byte, output end_of_message, input ready);
   modport sink (input valid, input plain_byte, input end_of_message, output ready);
endinterface

interface rc4_rsp_if;
   import rc4_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;
   logic       final_byte;

   modport source (output valid, output cipher_byte, output final_byte, input ready);
   modport sink (input valid, input cipher_byte, input final_byte, output ready);
endinterface

interface rc4_csr_if;
   import rc4_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

FILE: rtl/core/rc4_ram.sv
module rc4_ram #(
   parameter int WIDTH = rc4_pkg::PERM_W,
   parameter int DEPTH = rc4_pkg::PERM_SIZE
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem_ff[waddr] <= wdata;
      if (re)
         rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/core/rc4_engine.sv
module rc4_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  rc4_pkg::key_type                key,
   rc4_req_if.sink                         req,
   rc4_rsp_if.source                       rsp,
   output rc4_pkg::ram_req_type            ram_req,
   input  logic [rc4_pkg::PERM_W-1:0]      ram_rdata
);
   import rc4_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FILL,
      S_K_RD_N, S_K_RD_J, S_K_WR_N, S_K_WR_J,
      S_P_RD_I, S_P_RD_J, S_P_WR_I, S_P_WR_J
   } state_type;

   localparam logic [PERM_ADDR_W-1:0] PERM_LAST = PERM_ADDR_W'(PERM_SIZE - 1);

   state_type              state_ff, state_in;
   logic [PERM_ADDR_W-1:0] cnt_ff, cnt_in;
   logic [PERM_W-1:0]      i_ff, i_in;
   logic [PERM_W-1:0]      j_ff, j_in;
   logic [PERM_W-1:0]      a_ff, a_in;
   logic [PERM_W-1:0]      b_ff, b_in;
   logic [PERM_W-1:0]      t_ff, t_in;
   logic [KEY_POS_W-1:0]   kpos_ff, kpos_in;
   logic [7:0]             plain_ff, plain_in;
   logic                   last_ff, last_in;
   logic                   rekey_ff, rekey_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_final_ff, rsp_final_in;

   logic [7:0]             key_byte;
   logic [KEY_LEN_W-1:0]   kpos_inc;
   logic [PERM_W-1:0]      j_sum;
   logic [PERM_W-1:0]      ks;

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cipher_byte = rsp_byte_ff;
   assign rsp.final_byte  = rsp_final_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      kpos_in      = kpos_ff;
      plain_in     = plain_ff;
      last_in      = last_ff;
      rekey_in     = rekey_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_final_in = rsp_final_ff;
      ram_req      = '0;

      key_byte = key.words[kpos_ff[KEY_POS_W-1:3]][{kpos_ff[2:0], 3'b000} +: 8];
      kpos_inc = KEY_LEN_W'(kpos_ff) + KEY_LEN_W'(1);
      j_sum    = '0;
      // the swap may have landed on the keystream index: take it from the registers
      ks = (t_ff == j_ff) ? a_ff : ((t_ff == i_ff) ? b_ff : ram_rdata);

      if (rsp_valid_ff && rsp.ready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               plain_in = req.plain_byte;
               last_in  = req.end_of_message;
               if (rekey_ff) begin
                  cnt_in   = '0;
                  state_in = S_FILL;
               end else begin
                  i_in          = i_ff + PERM_W'(1);
                  ram_req.re    = 1'b1;
                  ram_req.raddr = i_ff + PERM_W'(1);
                  state_in      = S_P_RD_J;
               end
            end
         end
         S_FILL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = PERM_W'(cnt_ff);
            cnt_in        = cnt_ff + PERM_ADDR_W'(1);
            if (cnt_ff == PERM_LAST) begin
               j_in     = '0;
               kpos_in  = '0;
               state_in = S_K_RD_N;
            end
         end
         S_K_RD_N: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = cnt_ff;
            state_in      = S_K_RD_J;
         end
         S_K_RD_J: begin
            j_sum         = j_ff + ram_rdata + key_byte;
            a_in          = ram_rdata;
            j_in          = j_sum;
            ram_req.re    = 1'b1;
            ram_req.raddr = j_sum;
            kpos_in       = (kpos_inc >= eff_key_length(key.length)) ? '0 :
                            kpos_inc[KEY_POS_W-1:0];
            state_in      = S_K_WR_N;
         end
         S_K_WR_N: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_ff;
            ram_req.wdata = ram_rdata;
            state_in      = S_K_WR_J;
         end
         S_K_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = a_ff;
            cnt_in        = cnt_ff + PERM_ADDR_W'(1);
            if (cnt_ff == PERM_LAST) begin
               i_in     = '0;
               j_in     = '0;
               rekey_in = 1'b0;
               state_in = S_P_RD_I;
            end else begin
               state_in = S_K_RD_N;
            end
         end
         S_P_RD_I: begin
            i_in          = i_ff + PERM_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = i_ff + PERM_W'(1);
            state_in      = S_P_RD_J;
         end
         S_P_RD_J: begin
            j_sum         = j_ff + ram_rdata;
            a_in          = ram_rdata;
            j_in          = j_sum;
            ram_req.re    = 1'b1;
            ram_req.raddr = j_sum;
            state_in      = S_P_WR_I;
         end
         S_P_WR_I: begin
            b_in          = ram_rdata;
            t_in          = a_ff + ram_rdata;
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = ram_rdata;
            ram_req.re    = 1'b1;
            ram_req.raddr = a_ff + ram_rdata;
            state_in      = S_P_WR_J;
         end
         S_P_WR_J: begin
            // repeat the write while stalled; read data holds with no read issued
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = a_ff;
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = plain_ff ^ ks;
               rsp_final_in = last_ff;
               rekey_in     = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rekey_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rekey_ff     <= rekey_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
      cnt_ff       <= cnt_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      t_ff         <= t_in;
      kpos_ff      <= kpos_in;
      plain_ff     <= plain_in;
      last_ff      <= last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_final_ff <= rsp_final_in;
   end

   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_P_WR_J))
      else $error("result raised outside the final keystream step");

   a_rekey_starts_fill: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && rekey_ff) |=> (state_ff == S_FILL))
      else $error("item taken with rekey pending did not start the fill");

   a_ksa_leaves_zero_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_RD_I) |-> (i_ff == '0 && j_ff == '0))
      else $error("indexes not cleared after key scheduling");

   a_rekey_clears_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(rekey_ff) |-> $past(state_ff == S_K_WR_J && cnt_ff == PERM_LAST))
      else $error("rekey flag dropped before key scheduling finished");

endmodule

FILE: rtl/core/rc4_stream_cipher_unit.sv
// Channel  Role    Handshake      Payload
// req_if   sink    valid/ready    plain_byte[7:0], end_of_message
// rsp_if   source  valid/ready    cipher_byte[7:0], final_byte
// csr_if   sink    valid/ready    reg_index[2:0], write_data[63:0]
//
// A byte in mid-message reads S[i], reads S[j], writes S[i] while reading S[a+b],
// then writes S[j] and registers the result; every access goes through the one read
// and one write port of the permutation RAM. The first byte of each message first
// fills the RAM with the identity, then runs 256 swaps on the same RAM, then issues
// the S[i] read. Reset is synchronous; it clears control state and the key words,
// sets the key length to one; the first byte after reset schedules the key.
// A stalled result holds the last swap; csr_if is always ready.
module rc4_stream_cipher_unit (
   input logic       clock,
   input logic       reset,
   rc4_req_if.sink   req_if,
   rc4_rsp_if.source rsp_if,
   rc4_csr_if.sink   csr_if
);
   import rc4_pkg::*;

   logic [KEY_LEN_W-1:0]                  key_length_ff, key_length_in;
   logic [KEY_WORDS-1:0][KEY_WORD_W-1:0]  key_words_ff, key_words_in;
   key_type                               key;
   ram_req_type                           ram_req;
   logic [PERM_W-1:0]                     ram_rdata;

   assign csr_if.ready = 1'b1;

   always_comb begin
      key_length_in = key_length_ff;
      key_words_in  = key_words_ff;
      if (csr_if.valid) begin
         unique case (csr_if.reg_index)
            REG_KEY_LENGTH: key_length_in   = csr_if.write_data[KEY_LEN_W-1:0];
            REG_KEY_WORD_0: key_words_in[0] = csr_if.write_data;
            REG_KEY_WORD_1: key_words_in[1] = csr_if.write_data;
            REG_KEY_WORD_2: key_words_in[2] = csr_if.write_data;
            REG_KEY_WORD_3: key_words_in[3] = csr_if.write_data;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_W'(1);
         key_words_ff  <= '0;
      end else begin
         key_length_ff <= key_length_in;
         key_words_ff  <= key_words_in;
      end
   end

   assign key.length = key_length_ff;
   assign key.words  = key_words_ff;

   rc4_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .key       (key),
      .req       (req_if),
      .rsp       (rsp_if),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   rc4_ram #(
      .WIDTH (PERM_W),
      .DEPTH (PERM_SIZE)
   ) u_perm_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule
